// ----- sv/med9fe_pkg.sv -----
package med9fe_pkg;

   // Sample width and window geometry
   localparam int SAMPLE_BITS = 16;
   localparam int WIN = 9;
   localparam int IDX_BITS = $clog2(WIN);
   localparam int CNT_BITS = 4;
   // Odd-even transposition needs as many exchange stages as entries
   localparam int SORT_STAGES = WIN;
   localparam logic [CNT_BITS-1:0] CNT_ALL_FILL = CNT_BITS'(WIN);
   localparam logic [SAMPLE_BITS-1:0] FILL_RESET = '1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type window_type [WIN];

   typedef struct packed {
      sample_type sample_0;
      sample_type sample_1;
      sample_type sample_2;
      sample_type sample_3;
      sample_type sample_4;
      sample_type sample_5;
      sample_type sample_6;
      sample_type sample_7;
      sample_type sample_8;
      logic [CNT_BITS-1:0] invalid_count;
   } req_type;

   typedef struct packed {
      sample_type median_out;
      logic all_fill;
   } rsp_type;

endpackage

// ----- sv/median9_fill_exclusion.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  med9fe_pkg::req_type
// rsp      out        rsp_valid / rsp_stall  med9fe_pkg::rsp_type
// csr      in         csr_write              csr_data (fill value)
//
// Twelve register stages: input capture, nine compare-exchange stages of the
// sorting network, middle-pair select, and the rounded mean / output register.
// One item per cycle sustained while rsp_stall is low.
// Each stage moves when it is empty or the stage after it moves, so bubbles
// close up and an item can still be taken while a finished result waits on rsp_stall.
// Synchronous active-high reset clears the valid bits and sets the fill value to -1.
module median9_fill_exclusion (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  med9fe_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output med9fe_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  med9fe_pkg::sample_type csr_data
);
   import med9fe_pkg::*;

   // stage 0 capture, 1..SORT_STAGES sort, then select, then output
   localparam int PICK_STG = SORT_STAGES + 1;
   localparam int OUT_STG = SORT_STAGES + 2;
   localparam int NSTG = SORT_STAGES + 3;

   logic [NSTG-1:0] valid_ff;
   logic [NSTG:0]   adv;

   window_type win_ff [SORT_STAGES+1];
   window_type win_in [SORT_STAGES+1];
   logic [CNT_BITS-1:0] cnt_ff [SORT_STAGES+1];
   logic [CNT_BITS-1:0] cnt_in;

   sample_type hi_ff, lo_ff, hi_in, lo_in;
   logic       all_pick_ff;
   sample_type fill_ff;
   rsp_type    rsp_ff, rsp_in;

   logic [IDX_BITS-1:0] hi_idx, lo_idx;
   logic [CNT_BITS:0]   hi_sum, lo_sum;
   logic signed [SAMPLE_BITS:0] pair_sum;

   // Stage advance chain from the output back
   always_comb begin
      adv[NSTG] = !rsp_stall;
      for (int k = NSTG - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[OUT_STG];
   assign rsp_data  = rsp_ff;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Fill value register
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= FILL_RESET;
      end else if (csr_write) begin
         fill_ff <= csr_data;
      end
   end

   // Input capture; counts above nine saturate
   always_comb begin
      win_in[0][0] = req_data.sample_0;
      win_in[0][1] = req_data.sample_1;
      win_in[0][2] = req_data.sample_2;
      win_in[0][3] = req_data.sample_3;
      win_in[0][4] = req_data.sample_4;
      win_in[0][5] = req_data.sample_5;
      win_in[0][6] = req_data.sample_6;
      win_in[0][7] = req_data.sample_7;
      win_in[0][8] = req_data.sample_8;
      cnt_in = (req_data.invalid_count >= CNT_ALL_FILL) ? CNT_ALL_FILL
                                                        : req_data.invalid_count;
      // One compare-exchange layer per stage, pairs alternate odd/even
      for (int s = 1; s <= SORT_STAGES; s++) begin
         win_in[s] = win_ff[s-1];
         for (int k = (s - 1) % 2; k + 1 < WIN; k += 2) begin
            if (win_ff[s-1][k] > win_ff[s-1][k+1]) begin
               win_in[s][k]   = win_ff[s-1][k+1];
               win_in[s][k+1] = win_ff[s-1][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         win_ff[0] <= win_in[0];
         cnt_ff[0] <= cnt_in;
      end
      for (int s = 1; s <= SORT_STAGES; s++) begin
         if (adv[s]) begin
            win_ff[s] <= win_in[s];
            cnt_ff[s] <= cnt_ff[s-1];
         end
      end
   end

   // Middle pair: hi = (cnt+9)/2, lo = (cnt+8)/2; equal when the valid count is odd
   always_comb begin
      hi_sum = {1'b0, cnt_ff[SORT_STAGES]} + (CNT_BITS+1)'(WIN);
      lo_sum = {1'b0, cnt_ff[SORT_STAGES]} + (CNT_BITS+1)'(WIN - 1);
      hi_idx = hi_sum[IDX_BITS:1];
      lo_idx = lo_sum[IDX_BITS:1];
      if (cnt_ff[SORT_STAGES] == CNT_ALL_FILL) begin
         hi_idx = '0;
         lo_idx = '0;
      end
      hi_in = win_ff[SORT_STAGES][hi_idx];
      lo_in = win_ff[SORT_STAGES][lo_idx];
   end

   always_ff @(posedge clock) begin
      if (adv[PICK_STG]) begin
         hi_ff       <= hi_in;
         lo_ff       <= lo_in;
         all_pick_ff <= (cnt_ff[SORT_STAGES] == CNT_ALL_FILL);
      end
   end

   // Mean rounded up at .5, or the fill value when nothing is valid
   always_comb begin
      pair_sum = {hi_ff[SAMPLE_BITS-1], hi_ff} + {lo_ff[SAMPLE_BITS-1], lo_ff}
                 + (SAMPLE_BITS+1)'(1);
      rsp_in.all_fill   = all_pick_ff;
      rsp_in.median_out = all_pick_ff ? fill_ff : pair_sum[SAMPLE_BITS:1];
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_STG]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- verif/tb_median9_fill_exclusion.sv -----
module tb_median9_fill_exclusion;
   import med9fe_pkg::*;

   localparam sample_type S_MAX = 16'sh7FFF;
   localparam sample_type S_MIN = 16'sh8000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int NUM_PHASES = 5;
   localparam int RANDOM_PER_PHASE = 76;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   sample_type csr_data = '0;

   // Testbench copy of the fill register, plus traffic bookkeeping
   sample_type fill_setting = FILL_RESET;
   req_type window_queue[$];
   rsp_type median_expected[$];
   rsp_type median_want;
   bit quiet = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_mark = 30;
   int windows_sent = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int holds_done = 0;
   int idle_cycles = 0;

   median9_fill_exclusion uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // Sort the window, drop the fill count from the bottom, take the middle
   function automatic rsp_type predict_median(req_type item, sample_type fill);
      window_type w;
      sample_type t;
      int cnt, n, s, k;
      logic signed [SAMPLE_BITS+1:0] pair_sum;
      rsp_type r;
      cnt = item.invalid_count;
      r.all_fill = 1'b0;
      if (cnt >= WIN) begin
         r.median_out = fill;
         r.all_fill = 1'b1;
         return r;
      end
      w = '{item.sample_0, item.sample_1, item.sample_2, item.sample_3, item.sample_4,
            item.sample_5, item.sample_6, item.sample_7, item.sample_8};
      // odd-even transposition, one pass per entry
      for (s = 0; s < WIN; s++) begin
         for (k = s % 2; k + 1 < WIN; k += 2) begin
            if (w[k] > w[k+1]) begin
               t = w[k];
               w[k] = w[k+1];
               w[k+1] = t;
            end
         end
      end
      n = WIN - cnt;
      if (n % 2 == 1) begin
         r.median_out = w[cnt + (n - 1) / 2];
      end else begin
         // mean of the middle pair, rounded up at .5
         pair_sum = w[cnt + n / 2] + w[cnt + n / 2 - 1] + 1;
         r.median_out = sample_type'(pair_sum >>> 1);
      end
      return r;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Random window; most carry the fill marker in cnt entries, some are pure noise
   function automatic req_type random_window(sample_type fill);
      window_type v;
      sample_type t;
      int cnt, style, k, j;
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
      style = $urandom_range(0, 9);
      for (k = 0; k < WIN; k++) begin
         if (style >= 5 && style < 7) begin
            // narrow range makes duplicates likely
            v[k] = sample_type'(int'($urandom_range(0, 16)) - 8);
         end else if (style == 7) begin
            case ($urandom_range(0, 3))
               0: v[k] = S_MAX;
               1: v[k] = S_MIN;
               2: v[k] = '0;
               default: v[k] = '1;
            endcase
         end else begin
            v[k] = sample_type'($urandom);
         end
      end
      if ($urandom_range(0, 9) < 6) begin
         for (k = 0; k < cnt && k < WIN; k++) v[k] = fill;
         for (k = WIN - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = v[k];
            v[k] = v[j];
            v[j] = t;
         end
      end
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 4'(cnt)};
   endfunction

   task automatic queue_window(window_type v, int cnt);
      window_queue.push_back({v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                              4'(cnt)});
   endtask

   // Driver: offers queued items, holds the payload while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            median_expected.push_back(predict_median(req_data, fill_setting));
            windows_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the item
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (window_queue.size() > 0) begin
            req_data <= window_queue.pop_front();
            req_valid <= 1'b1;
            send_gap = quiet ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result against the oldest prediction, drives stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (median_expected.size() == 0) begin
               $display("%0t: unexpected item: median_out=%0d all_fill=%0b",
                        $time, rsp_data.median_out, rsp_data.all_fill);
               mismatch_count++;
            end else begin
               median_want = median_expected.pop_front();
               if (rsp_data.median_out !== median_want.median_out) begin
                  $display("%0t: median_out mismatch: expected %0d, actual %0d",
                           $time, median_want.median_out, rsp_data.median_out);
                  mismatch_count++;
               end
               if (rsp_data.all_fill !== median_want.all_fill) begin
                  $display("%0t: all_fill mismatch: expected %0b, actual %0b",
                           $time, median_want.all_fill, rsp_data.all_fill);
                  mismatch_count++;
               end
            end
            results_checked++;
         end
         // long hold-off now and then so the pipeline backs up into the input
         if (hold_left == 0 && results_checked >= hold_mark) begin
            hold_left = HOLD_CYCLES;
            hold_mark += 250;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = quiet ? 0 : pick_gap();
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   // Watchdog on cycles with no accept on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: timeout, %0d results still pending", $time,
                        median_expected.size());
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   // Stimulus: directed windows, then random phases under different fill values
   initial begin
      window_type v;
      sample_type fills[NUM_PHASES];
      int p, c, k, i;
      fills[0] = FILL_RESET;
      fills[1] = S_MAX;
      fills[2] = S_MIN;
      fills[3] = '0;
      fills[4] = sample_type'($urandom);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes of the samples
      queue_window('{default: '0}, 0);
      queue_window('{default: S_MAX}, 0);
      queue_window('{default: S_MIN}, 0);
      // even count with the middle pair at opposite extremes
      queue_window('{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN}, 1);
      // every fill count, including the saturating ones
      for (c = 0; c < 16; c++) begin
         for (k = 0; k < WIN; k++) v[k] = sample_type'(((k * 7 + c) % 9) * 3001 - 12000);
         queue_window(v, c);
      end
      // fill not lowest: real samples get dropped from the bottom
      queue_window('{16'sd900, 16'sd800, 16'sd700, 16'sd600, 16'sd500, 16'sd400,
                     16'sd300, 16'sd200, 16'sd100}, 4);
      // rounding of the middle pair, negative and positive
      queue_window('{S_MIN, S_MIN, -16'sd3, S_MIN, S_MIN, -16'sd2, S_MIN, S_MIN, S_MIN}, 7);
      queue_window('{S_MIN, 16'sd3, S_MIN, S_MIN, S_MIN, S_MIN, 16'sd2, S_MIN, S_MIN}, 7);

      for (p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) begin
            // register writes only with the pipeline drained
            @(negedge clock);
            while (window_queue.size() > 0 || req_valid || median_expected.size() > 0)
               @(negedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
            csr_write <= 1'b1;
            csr_data <= fills[p];
            fill_setting = fills[p];
            @(posedge clock);
            csr_write <= 1'b0;
         end
         quiet = (p == 2);
         @(negedge clock);
         for (i = 0; i < RANDOM_PER_PHASE + ((p > 0) ? 4 : 0); i++)
            window_queue.push_back(random_window(fill_setting));
      end

      @(negedge clock);
      while (window_queue.size() > 0 || req_valid || median_expected.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d windows over %0d fill settings, checked %0d results.",
               windows_sent, NUM_PHASES, results_checked);
      $display("Long receiver hold-offs: %0d, mismatches: %0d.", holds_done, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
